FILE: rtl/tsp_pkg.sv
// ============================================================================
// Tone sequence player package
// Shared types, codes and the constant step and sequence tables.
// ============================================================================
`default_nettype none

package tsp_pkg;

    typedef enum logic
    {
        ACT_TICK    = 1'b0,
        ACT_REQUEST = 1'b1
    } tsp_action_t;

    typedef enum logic [2:0]
    {
        SEQ_POWERUP = 3'd0,
        SEQ_FAULT   = 3'd1,
        SEQ_ADDED   = 3'd2,
        SEQ_STARTED = 3'd3,
        SEQ_STOPPED = 3'd4,
        SEQ_CLICK   = 3'd5,
        SEQ_BACK    = 3'd6,
        SEQ_MUTE    = 3'd7
    } tsp_tone_t;

    localparam int FREQ_W     = 11;
    localparam int MS_W       = 9;
    localparam int ROM_ADDR_W = 5;

    typedef struct packed
    {
        logic [FREQ_W-1:0] hz;
        logic [MS_W-1:0]   ms;
    } tsp_step_t;

    typedef struct packed
    {
        logic [3:0] base;
        logic [1:0] len;
        logic       loops;
    } tsp_seq_t;

    typedef struct packed
    {
        logic [3:0]        base;
        logic [1:0]        len;
        logic [1:0]        step_index;
        logic              loop_mode;
        logic              active;
        logic [FREQ_W-1:0] freq;
    } tsp_ctl_t;

    localparam int CTL_W = $bits(tsp_ctl_t);

    function automatic tsp_step_t step_rom(input logic [ROM_ADDR_W-1:0] addr);
        tsp_step_t s;
        case (addr)
            5'd0:    s = '{hz: 11'd523,  ms: 9'd120};
            5'd1:    s = '{hz: 11'd659,  ms: 9'd120};
            5'd2:    s = '{hz: 11'd784,  ms: 9'd180};
            5'd3:    s = '{hz: 11'd1000, ms: 9'd400};
            5'd4:    s = '{hz: 11'd0,    ms: 9'd200};
            5'd5:    s = '{hz: 11'd880,  ms: 9'd80};
            5'd6:    s = '{hz: 11'd0,    ms: 9'd40};
            5'd7:    s = '{hz: 11'd880,  ms: 9'd80};
            5'd8:    s = '{hz: 11'd440,  ms: 9'd60};
            5'd9:    s = '{hz: 11'd880,  ms: 9'd120};
            5'd10:   s = '{hz: 11'd880,  ms: 9'd60};
            5'd11:   s = '{hz: 11'd440,  ms: 9'd120};
            5'd12:   s = '{hz: 11'd2000, ms: 9'd20};
            5'd13:   s = '{hz: 11'd600,  ms: 9'd40};
            5'd14:   s = '{hz: 11'd300,  ms: 9'd60};
            default: s = '{hz: '0, ms: '0};
        endcase
        return s;
    endfunction

    function automatic tsp_seq_t seq_desc(input tsp_tone_t tone);
        tsp_seq_t d;
        case (tone)
            SEQ_POWERUP: d = '{base: 4'd0,  len: 2'd3, loops: 1'b0};
            SEQ_FAULT:   d = '{base: 4'd3,  len: 2'd2, loops: 1'b1};
            SEQ_ADDED:   d = '{base: 4'd5,  len: 2'd3, loops: 1'b0};
            SEQ_STARTED: d = '{base: 4'd8,  len: 2'd2, loops: 1'b0};
            SEQ_STOPPED: d = '{base: 4'd10, len: 2'd2, loops: 1'b0};
            SEQ_CLICK:   d = '{base: 4'd12, len: 2'd1, loops: 1'b0};
            SEQ_BACK:    d = '{base: 4'd13, len: 2'd2, loops: 1'b0};
            default:     d = '{base: '0, len: '0, loops: 1'b0};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tsp_ram.sv
// ============================================================================
// Generic RAM
// Single write port and single read port with registered read data.
// ============================================================================
`default_nettype none

module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/tsp_step.sv
// ============================================================================
// Tone sequence step logic
// Computes the next player state from the current state and one transaction.
// ============================================================================
`default_nettype none

module tsp_step #(
    parameter int TIME_BITS = 32,
    parameter int STEP_ROM_DEPTH = 16
) (
    input  wire tsp_pkg::tsp_ctl_t    cur_ctl,
    input  wire logic [TIME_BITS-1:0] cur_deadline,
    input  wire tsp_pkg::tsp_action_t action,
    input  wire tsp_pkg::tsp_tone_t   tone_id,
    input  wire logic [TIME_BITS-1:0] now,
    output tsp_pkg::tsp_ctl_t         nxt_ctl,
    output logic      [TIME_BITS-1:0] nxt_deadline
);

    import tsp_pkg::*;

    tsp_seq_t                desc;
    tsp_step_t               step;
    logic [2:0]              next_idx;
    logic [TIME_BITS-1:0]    diff;
    logic [ROM_ADDR_W-1:0]   addr;
    logic                    load;

    always_comb
    begin
        nxt_ctl      = cur_ctl;
        nxt_deadline = cur_deadline;
        load         = 1'b0;
        desc         = seq_desc(tone_id);
        next_idx     = {1'b0, cur_ctl.step_index} + 3'd1;
        diff         = now - cur_deadline;
        if (action == ACT_REQUEST)
        begin
            if (tone_id == SEQ_MUTE)
            begin
                nxt_ctl.active    = 1'b0;
                nxt_ctl.loop_mode = 1'b0;
                nxt_ctl.freq      = '0;
            end
            else
            begin
                nxt_ctl.base       = desc.base;
                nxt_ctl.len        = desc.len;
                nxt_ctl.loop_mode  = desc.loops;
                nxt_ctl.step_index = '0;
                nxt_ctl.active     = 1'b1;
                load               = 1'b1;
            end
        end
        else if (cur_ctl.active && !diff[TIME_BITS-1])
        begin
            if (next_idx >= {1'b0, cur_ctl.len})
            begin
                if (cur_ctl.loop_mode)
                begin
                    nxt_ctl.step_index = '0;
                    load               = 1'b1;
                end
                else
                begin
                    nxt_ctl.active = 1'b0;
                    nxt_ctl.freq   = '0;
                end
            end
            else
            begin
                nxt_ctl.step_index = next_idx[1:0];
                load               = 1'b1;
            end
        end
        addr = {1'b0, nxt_ctl.base} + {3'b000, nxt_ctl.step_index};
        if (int'(addr) >= STEP_ROM_DEPTH)
        begin
            step = '{hz: '0, ms: '0};
        end
        else
        begin
            step = step_rom(addr);
        end
        if (load)
        begin
            nxt_ctl.freq = step.hz;
            nxt_deadline = now + TIME_BITS'(step.ms);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tone_sequence_player_top.sv
// ============================================================================
// Tone sequence player top level
// Buzzer tone sequencer with the player state held in a small RAM.
// ============================================================================
// The block takes one transaction per clock cycle, tone requests and time
// ticks alike, unless the output side stalls, and returns exactly one result
// transaction for each, registered once the output side is ready. The player
// state lives in a single RAM entry that is read when a transaction is accepted
// and written back when its result is registered; a back-to-back transaction
// takes the written value through a forwarding path, so the read-modify-write
// loop of that entry sets that rate. A state flag stands in for the RAM contents
// until the first write, so no clearing pass follows reset.
`default_nettype none

module tone_sequence_player_top #(
    parameter int TIME_BITS = 32,
    parameter int STEP_ROM_DEPTH = 16,
    parameter int PWM_BITS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // now_ms[31:0]
    input  wire logic [3:0]  s_axis_tuser,  // action[0], tone_id[3:1]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [((tsp_pkg::FREQ_W + PWM_BITS + 1 + 7) / 8) * 8 - 1:0]
                             m_axis_tdata   // freq_hz, pwm_duty, playing
);

    import tsp_pkg::*;

    localparam int OUT_W  = FREQ_W + PWM_BITS + 1;
    localparam int M_W    = ((OUT_W + 7) / 8) * 8;
    localparam int WORD_W = CTL_W + TIME_BITS;
    localparam int DEPTH  = 2;
    localparam int ADDR_W = 1;
    localparam logic [ADDR_W-1:0] STATE_ADDR = '0;
    localparam logic [PWM_BITS-1:0] DUTY_ON = PWM_BITS'(1) << (PWM_BITS - 1);

    logic                 accept;
    logic                 advance;
    logic                 item_valid_reg;
    tsp_action_t          item_action_reg;
    tsp_tone_t            item_tone_reg;
    logic [TIME_BITS-1:0] item_now_reg;
    logic                 hazard_reg;
    logic                 init_reg;
    logic [WORD_W-1:0]    fwd_word_reg;
    logic [WORD_W-1:0]    rd_word;
    logic [WORD_W-1:0]    cur_word;
    logic [WORD_W-1:0]    wr_word;
    tsp_ctl_t             cur_ctl;
    tsp_ctl_t             nxt_ctl;
    logic [TIME_BITS-1:0] cur_deadline;
    logic [TIME_BITS-1:0] nxt_deadline;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;
    logic [OUT_W-1:0]     out_data_next;
    logic [PWM_BITS-1:0]  duty;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign advance       = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            hazard_reg     <= 1'b0;
            init_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
                hazard_reg     <= advance;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                init_reg      <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_action_reg <= tsp_action_t'(s_axis_tuser[0]);
            item_tone_reg   <= tsp_tone_t'(s_axis_tuser[3:1]);
            item_now_reg    <= TIME_BITS'(s_axis_tdata);
        end
        if (advance)
        begin
            fwd_word_reg <= wr_word;
            out_data_reg <= out_data_next;
        end
    end

    tsp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_state_ram (
        .clk  (clk),
        .we   (advance),
        .waddr(STATE_ADDR),
        .wdata(wr_word),
        .re   (accept),
        .raddr(STATE_ADDR),
        .rdata(rd_word)
    );

    always_comb
    begin
        if (!init_reg)
        begin
            cur_word = '0;
        end
        else if (hazard_reg)
        begin
            cur_word = fwd_word_reg;
        end
        else
        begin
            cur_word = rd_word;
        end
    end

    assign cur_ctl      = tsp_ctl_t'(cur_word[WORD_W-1:TIME_BITS]);
    assign cur_deadline = cur_word[TIME_BITS-1:0];

    tsp_step #(
        .TIME_BITS     (TIME_BITS),
        .STEP_ROM_DEPTH(STEP_ROM_DEPTH)
    ) u_step (
        .cur_ctl     (cur_ctl),
        .cur_deadline(cur_deadline),
        .action      (item_action_reg),
        .tone_id     (item_tone_reg),
        .now         (item_now_reg),
        .nxt_ctl     (nxt_ctl),
        .nxt_deadline(nxt_deadline)
    );

    assign wr_word       = {nxt_ctl, nxt_deadline};
    assign duty          = (nxt_ctl.freq != '0) ? DUTY_ON : '0;
    assign out_data_next = {nxt_ctl.active, duty, nxt_ctl.freq};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_W'(out_data_reg);

endmodule

`default_nettype wire

FILE: rtl/tsp_checker.sv
// ============================================================================
// Tone sequence player checker
// Port-level assertions on the output stream and the input handshake.
// ============================================================================
`default_nettype none

module tsp_checker #(
    parameter int PWM_BITS = 10,
    parameter int M_W = 24
) (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           s_axis_tready,
    input wire logic           m_axis_tvalid,
    input wire logic           m_axis_tready,
    input wire logic [M_W-1:0] m_axis_tdata
);

    import tsp_pkg::*;

    localparam logic [PWM_BITS-1:0] DUTY_ON = PWM_BITS'(1) << (PWM_BITS - 1);

    logic [FREQ_W-1:0]   freq;
    logic [PWM_BITS-1:0] duty;
    logic                playing;

    assign freq    = m_axis_tdata[FREQ_W-1:0];
    assign duty    = m_axis_tdata[FREQ_W+PWM_BITS-1:FREQ_W];
    assign playing = m_axis_tdata[FREQ_W+PWM_BITS];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output transaction changed while stalled.");

    a_duty_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (freq == '0 && duty == '0) || (freq != '0 && duty == DUTY_ON))
        else $error("Duty does not match frequency.");

    a_tone_playing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && freq != '0 |-> playing)
        else $error("Tone driven while not playing.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("Input stalled without output backpressure.");

endmodule

bind tone_sequence_player_top tsp_checker #(
    .PWM_BITS(PWM_BITS),
    .M_W     (M_W)
) u_tsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
